// ===== hw/rtl/fbw_pkg.sv =====
`default_nettype none

package fbw_pkg;

    localparam int BEAMS           = 4;
    localparam int WEIGHT_W        = 16;
    localparam int DIAM_W          = 20;
    localparam int EDGE_W          = 16;
    localparam int VALID_W         = 3;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 20;
    localparam int COUNT_BITS_DEF  = 16;
    localparam int WEIGHT_FRAC_DEF = 12;

    localparam logic [DIAM_W-1:0]   DIAM_MAX      = 20'hFFFFF;
    localparam logic [EDGE_W-1:0]   EDGE_MAX      = 16'hFFFF;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET  = 16'd4096;
    localparam logic [DIAM_W-1:0]   MIN_WIDTH_RST = 20'd1;

    localparam logic [VALID_W-1:0] NV_TWO   = 3'd2;
    localparam logic [VALID_W-1:0] NV_THREE = 3'd3;
    localparam logic [VALID_W-1:0] NV_FOUR  = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WEIGHT_A    = 3'd0,
        CFG_WEIGHT_B    = 3'd1,
        CFG_WEIGHT_C    = 3'd2,
        CFG_WEIGHT_D    = 3'd3,
        CFG_MIN_WIDTH   = 3'd4,
        CFG_SCAN_ENABLE = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [BEAMS-1:0][WEIGHT_W-1:0] weight;
        logic [DIAM_W-1:0]              min_width;
        logic                           scan_enable;
    } t_cfg;

    typedef struct packed {
        logic [DIAM_W-1:0]  diameter;
        logic [EDGE_W-1:0]  object_count;
        logic               diameter_updated;
        logic [VALID_W-1:0] valid_beams;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/fbw_if.sv =====
`default_nettype none

interface fbw_in_if import fbw_pkg::*;;
    logic             valid;
    logic             ready;
    logic [BEAMS-1:0] beam_levels;
    logic             restart;

    modport source (output valid, output beam_levels, output restart, input ready);
    modport sink (input valid, input beam_levels, input restart, output ready);
endinterface

interface fbw_out_if import fbw_pkg::*;;
    logic               valid;
    logic               ready;
    logic [DIAM_W-1:0]  diameter;
    logic [EDGE_W-1:0]  object_count;
    logic               diameter_updated;
    logic [VALID_W-1:0] valid_beams;

    modport source (output valid, output diameter, output object_count,
                    output diameter_updated, output valid_beams, input ready);
    modport sink (input valid, input diameter, input object_count,
                  input diameter_updated, input valid_beams, output ready);
endinterface

interface fbw_cfg_if import fbw_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/fbw_cfg_regs.sv =====
`default_nettype none

module fbw_cfg_regs import fbw_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fbw_cfg_if.sink   i_cfg,
    output t_cfg      o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_WEIGHT_A:    n_cfg.weight[0]   = i_cfg.data[WEIGHT_W-1:0];
                CFG_WEIGHT_B:    n_cfg.weight[1]   = i_cfg.data[WEIGHT_W-1:0];
                CFG_WEIGHT_C:    n_cfg.weight[2]   = i_cfg.data[WEIGHT_W-1:0];
                CFG_WEIGHT_D:    n_cfg.weight[3]   = i_cfg.data[WEIGHT_W-1:0];
                CFG_MIN_WIDTH:   n_cfg.min_width   = i_cfg.data[DIAM_W-1:0];
                CFG_SCAN_ENABLE: n_cfg.scan_enable = i_cfg.data[0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.weight      <= {BEAMS{WEIGHT_RESET}};
            r_cfg.min_width   <= MIN_WIDTH_RST;
            r_cfg.scan_enable <= 1'b1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/fbw_beam_track.sv =====
`default_nettype none

module fbw_beam_track import fbw_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire logic               i_restart,
    input  wire logic               i_scan,
    input  wire logic [BEAMS-1:0]   i_levels,
    output logic [COUNT_BITS-1:0]   o_high_ticks [BEAMS],
    output logic [EDGE_W-1:0]       o_edge_total,
    output logic [EDGE_W-1:0]       o_n_edge_total
);

    logic [COUNT_BITS-1:0] r_ht [BEAMS];
    logic [COUNT_BITS-1:0] n_ht [BEAMS];
    logic [BEAMS-1:0]      r_was;
    logic [BEAMS-1:0]      n_was;
    logic [EDGE_W-1:0]     r_edge;
    logic [EDGE_W-1:0]     n_edge;
    logic [BEAMS-1:0]      rises;
    logic [EDGE_W:0]       esum;

    // Several beams may rise on one tick; the saturating sum matches
    // one saturating increment per edge.
    always_comb begin
        n_ht   = r_ht;
        n_was  = r_was;
        n_edge = r_edge;
        rises  = i_levels & ~r_was;
        esum   = (EDGE_W+1)'(r_edge) + (EDGE_W+1)'($countones(rises));
        if (i_restart) begin
            for (int i = 0; i < BEAMS; i++) begin
                n_ht[i] = '0;
            end
            n_was  = '0;
            n_edge = '0;
        end else if (i_scan) begin
            for (int i = 0; i < BEAMS; i++) begin
                if (i_levels[i]) begin
                    if (!r_was[i]) begin
                        n_ht[i] = COUNT_BITS'(1);
                    end else if (!(&r_ht[i])) begin
                        n_ht[i] = r_ht[i] + 1'b1;
                    end
                end
            end
            n_was  = i_levels;
            n_edge = (esum > (EDGE_W+1)'(EDGE_MAX)) ? EDGE_MAX : esum[EDGE_W-1:0];
        end
    end

    assign o_high_ticks   = r_ht;
    assign o_edge_total   = r_edge;
    assign o_n_edge_total = n_edge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BEAMS; i++) begin
                r_ht[i] <= '0;
            end
            r_was  <= '0;
            r_edge <= '0;
        end else if (i_step) begin
            r_ht   <= n_ht;
            r_was  <= n_was;
            r_edge <= n_edge;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/fbw_width_calc.sv =====
`default_nettype none

module fbw_width_calc import fbw_pkg::*; #(
    parameter int COUNT_BITS       = COUNT_BITS_DEF,
    parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_DEF
) (
    input  wire logic [COUNT_BITS-1:0] i_high_ticks [BEAMS],
    input  wire t_cfg                  i_cfg,
    output logic [VALID_W-1:0]         o_nvalid,
    output logic [DIAM_W-1:0]          o_diameter
);

    localparam int PW = COUNT_BITS + WEIGHT_W;
    localparam int TW = DIAM_W + WEIGHT_FRAC_BITS;
    localparam int MW = (PW > TW) ? PW : TW;
    localparam int SW = PW + 1;
    localparam int XW = (SW > DIAM_W + 1) ? SW : DIAM_W + 1;

    logic [PW-1:0]    prod [BEAMS];
    logic [PW-1:0]    s    [BEAMS];
    logic [PW-1:0]    t;
    logic [BEAMS-1:0] hit;
    logic [MW-1:0]    thr;
    logic [SW-1:0]    sum;
    logic [XW-1:0]    q;

    // Rejected products sort to the top as all ones, so the valid ones
    // always occupy the lowest sorted slots.
    always_comb begin
        thr = MW'(i_cfg.min_width) << WEIGHT_FRAC_BITS;
        for (int i = 0; i < BEAMS; i++) begin
            prod[i] = PW'(i_high_ticks[i]) * PW'(i_cfg.weight[i]);
            hit[i]  = MW'(prod[i]) >= thr;
            s[i]    = hit[i] ? prod[i] : '1;
        end
        t = '0;
        if (s[0] > s[1]) begin t = s[0]; s[0] = s[1]; s[1] = t; end
        if (s[2] > s[3]) begin t = s[2]; s[2] = s[3]; s[3] = t; end
        if (s[0] > s[2]) begin t = s[0]; s[0] = s[2]; s[2] = t; end
        if (s[1] > s[3]) begin t = s[1]; s[1] = s[3]; s[3] = t; end
        if (s[1] > s[2]) begin t = s[1]; s[1] = s[2]; s[2] = t; end

        o_nvalid = VALID_W'($countones(hit));
        case (o_nvalid)
            NV_THREE: sum = {s[1], 1'b0};
            NV_FOUR:  sum = SW'(s[1]) + SW'(s[2]);
            default:  sum = SW'(s[0]) + SW'(s[1]);
        endcase
        q          = XW'(sum >> (WEIGHT_FRAC_BITS + 1));
        o_diameter = (q > XW'(DIAM_MAX)) ? DIAM_MAX : q[DIAM_W-1:0];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/four_beam_width_median_gauge.sv =====
// A word accepted into the input registers moves into the output registers once the output can take it.
// Throughput: one word per cycle while the output is not stalled; the beam state, four products and the sort
// are settled in the single stage between the input and output registers.
// Reset: synchronous, active low; clears counters, edge flags, object count,
// held diameter and both pipeline valids, and loads the register defaults.
`default_nettype none

module four_beam_width_median_gauge import fbw_pkg::*; #(
    parameter int COUNT_BITS       = COUNT_BITS_DEF,
    parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    fbw_in_if.sink     i_in,
    fbw_cfg_if.sink    i_cfg,
    fbw_out_if.source  o_out
);

    t_cfg                  cfg;
    logic [COUNT_BITS-1:0] high_ticks [BEAMS];
    logic [EDGE_W-1:0]     edge_total;
    logic [EDGE_W-1:0]     n_edge_total;
    logic [VALID_W-1:0]    nvalid;
    logic [DIAM_W-1:0]     calc_diam;

    logic                  r_in_vld;
    logic [BEAMS-1:0]      r_in_levels;
    logic                  r_in_restart;
    logic                  r_out_vld;
    t_result               r_out;
    t_result               n_out;
    logic [DIAM_W-1:0]     r_held;
    logic [DIAM_W-1:0]     n_held;

    logic                  adv;
    logic                  do_calc;
    logic                  upd;

    fbw_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    fbw_beam_track #(
        .COUNT_BITS (COUNT_BITS)
    ) u_track (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (adv),
        .i_restart      (r_in_restart),
        .i_scan         (cfg.scan_enable),
        .i_levels       (r_in_levels),
        .o_high_ticks   (high_ticks),
        .o_edge_total   (edge_total),
        .o_n_edge_total (n_edge_total)
    );

    fbw_width_calc #(
        .COUNT_BITS       (COUNT_BITS),
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_calc (
        .i_high_ticks (high_ticks),
        .i_cfg        (cfg),
        .o_nvalid     (nvalid),
        .o_diameter   (calc_diam)
    );

    assign adv        = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || adv;

    always_comb begin
        do_calc = !r_in_restart && cfg.scan_enable && (r_in_levels == '0);
        upd     = do_calc && (nvalid >= NV_TWO);
        if (r_in_restart) begin
            n_held = '0;
        end else if (upd) begin
            n_held = calc_diam;
        end else begin
            n_held = r_held;
        end
        n_out.diameter         = n_held;
        n_out.object_count     = n_edge_total;
        n_out.diameter_updated = upd;
        n_out.valid_beams      = do_calc ? nvalid : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_held    <= '0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_vld <= 1'b1;
            end else if (adv) begin
                r_in_vld <= 1'b0;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
                r_held    <= n_held;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_levels  <= i_in.beam_levels;
            r_in_restart <= i_in.restart;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid            = r_out_vld;
    assign o_out.diameter         = r_out.diameter;
    assign o_out.object_count     = r_out.object_count;
    assign o_out.diameter_updated = r_out.diameter_updated;
    assign o_out.valid_beams      = r_out.valid_beams;

    a_out_matches_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out.diameter == r_held))
        else $error("pending diameter differs from held diameter");

    a_out_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out.object_count == edge_total))
        else $error("pending object count differs from edge total");

    a_update_needs_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.diameter_updated) |-> (r_out.valid_beams >= NV_TWO))
        else $error("diameter updated from fewer than two widths");

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_restart) |=> (r_held == '0 && edge_total == '0))
        else $error("restart did not clear the state");

endmodule

`default_nettype wire
